/* rtl/assert_macros.svh */
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every rising clock edge outside reset.
`define B64D_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define B64D_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define B64D_ASSERT(lbl, clk, rst_n, prop, msg)
`define B64D_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* rtl/b64d_pkg.sv */
// Shared types and constants of the base64 stream decoder.
`timescale 1ns / 1ps
package b64d_pkg;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_NO_DATA = 2'd3
	} status_t;

	// Character class of one input byte.
	typedef struct packed {
		logic       blank;
		logic       pad;
		logic       sym;
		logic [5:0] value;
	} char_class_t;

	// Result of one character, as handed to the result register.
	typedef struct packed {
		logic       produce;
		logic       byte_valid;
		logic [7:0] out_byte;
		status_t    status;
		logic       frame_done;
	} result_t;

	localparam logic [7:0] CHAR_PAD = 8'h3D;

endpackage

/* rtl/b64d_in_if.sv */
// Handshake channel for encoded characters.
`timescale 1ns / 1ps
interface b64d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] input_char;
	logic       end_of_payload;

	modport source (output valid, output input_char, output end_of_payload, input ready);
	modport sink   (input valid, input input_char, input end_of_payload, output ready);
endinterface

/* rtl/b64d_out_if.sv */
// Handshake channel for decoded bytes and payload status.
`timescale 1ns / 1ps
interface b64d_out_if;
	logic       valid;
	logic       ready;
	logic       byte_valid;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       frame_done;

	modport source (output valid, output byte_valid, output out_byte, output status,
		output frame_done, input ready);
	modport sink   (input valid, input byte_valid, input out_byte, input status,
		input frame_done, output ready);
endinterface

/* rtl/b64d_classify.sv */
// Character classifier: whitespace, padding and the standard and URL-safe base64 alphabets.
`timescale 1ns / 1ps
module b64d_classify (
	input  logic [7:0]           ch,
	output b64d_pkg::char_class_t cls
);

	logic [7:0] diff;

	always_comb begin
		cls = '0;
		diff = 8'd0;
		case (ch) inside
			8'h20, [8'h09:8'h0D]: cls.blank = 1'b1;
			b64d_pkg::CHAR_PAD:   cls.pad = 1'b1;
			[8'h41:8'h5A]: begin
				diff = ch - 8'h41;
				cls.sym = 1'b1;
				cls.value = diff[5:0];
			end
			[8'h61:8'h7A]: begin
				diff = ch - 8'h61 + 8'd26;
				cls.sym = 1'b1;
				cls.value = diff[5:0];
			end
			[8'h30:8'h39]: begin
				diff = ch - 8'h30 + 8'd52;
				cls.sym = 1'b1;
				cls.value = diff[5:0];
			end
			8'h2B, 8'h2D: begin
				cls.sym = 1'b1;
				cls.value = 6'd62;
			end
			8'h2F, 8'h5F: begin
				cls.sym = 1'b1;
				cls.value = 6'd63;
			end
			default: cls = '0;
		endcase
	end

endmodule

/* rtl/b64d_core.sv */
// Decode state: 12-bit symbol window, pending bit count and payload flags.
`timescale 1ns / 1ps
module b64d_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          ch,
	input  logic                eop,
	output b64d_pkg::result_t   res
);

	b64d_pkg::char_class_t cls;

	logic [11:0] acc_q;
	logic [2:0]  pend_q;
	logic        pad_q;
	logic        inv_q;
	logic        sym_q;
	logic        emit_q;

	logic        active;
	logic        take;
	logic        have;
	logic [11:0] acc_n;
	logic [2:0]  pend_n;
	logic        sym_n;
	logic        inv_n;
	logic        emit_n;
	logic [7:0]  byte_n;

	b64d_classify u_classify (
		.ch  (ch),
		.cls (cls)
	);

	always_comb begin
		active = !cls.blank && !pad_q && !inv_q;
		take   = active && cls.sym;
		acc_n  = take ? {acc_q[5:0], cls.value} : acc_q;
		// pending is always even, so any nonzero count completes a byte
		have   = take && (pend_q != 3'd0);
		pend_n = take ? (have ? pend_q - 3'd2 : pend_q + 3'd6) : pend_q;
		sym_n  = sym_q | !cls.blank;
		inv_n  = inv_q | (active && !cls.pad && !cls.sym);
		emit_n = emit_q | have;
		case (pend_q)
			3'd2:    byte_n = acc_n[7:0];
			3'd4:    byte_n = acc_n[9:2];
			3'd6:    byte_n = acc_n[11:4];
			default: byte_n = acc_n[7:0];
		endcase

		res = '0;
		res.produce    = have || eop;
		res.byte_valid = have;
		res.out_byte   = have ? byte_n : 8'd0;
		res.frame_done = eop;
		if (!eop)                res.status = b64d_pkg::ST_OK;
		else if (!sym_n)         res.status = b64d_pkg::ST_EMPTY;
		else if (inv_n)          res.status = b64d_pkg::ST_INVALID;
		else if (!emit_n)        res.status = b64d_pkg::ST_NO_DATA;
		else                     res.status = b64d_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= '0;
			pad_q  <= 1'b0;
			inv_q  <= 1'b0;
			sym_q  <= 1'b0;
			emit_q <= 1'b0;
		end else if (fire) begin
			if (eop) begin
				acc_q  <= '0;
				pend_q <= '0;
				pad_q  <= 1'b0;
				inv_q  <= 1'b0;
				sym_q  <= 1'b0;
				emit_q <= 1'b0;
			end else begin
				acc_q  <= acc_n;
				pend_q <= pend_n;
				pad_q  <= pad_q | (active && cls.pad);
				inv_q  <= inv_n;
				sym_q  <= sym_n;
				emit_q <= emit_n;
			end
		end
	end

endmodule

/* rtl/base64_stream_decoder.sv */
// Top level of the URL-safe base64 stream decoder.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Streaming base64 decoder: one encoded character per beat on enc, at most one
// result per character on dec. Whitespace is skipped, '-' and '_' decode as '+'
// and '/', and everything after the first '=' in a payload is ignored. The beat
// with end_of_payload set yields a result with frame_done and a status (ok,
// invalid character, empty payload, nothing decoded), after which the decoder
// is back in its reset state for the next payload. Throughput is one character
// per clock while dec is not stalled. A character is held in the input register
// after it is accepted and decoded from there; its result moves into the result
// register when that is free or being taken, and is held there until taken.
// A character that completes no byte and is not last produces no beat on dec.
module base64_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	b64d_in_if.sink     enc,
	b64d_out_if.source  dec
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eop_s1;

	logic                valid_s2;
	b64d_pkg::result_t   res_s2;
	b64d_pkg::result_t   res;

	logic adv;
	logic fire;

	assign adv       = !valid_s2 || dec.ready;
	assign fire      = valid_s1 && adv;
	assign enc.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (enc.ready) begin
			valid_s1 <= enc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (enc.valid && enc.ready) begin
			char_s1 <= enc.input_char;
			eop_s1  <= enc.end_of_payload;
		end
	end

	b64d_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.ch     (char_s1),
		.eop    (eop_s1),
		.res    (res)
	);

	// drop characters that neither finish a byte nor end the payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= fire && res.produce;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign dec.valid      = valid_s2;
	assign dec.byte_valid = res_s2.byte_valid;
	assign dec.out_byte   = res_s2.out_byte;
	assign dec.status     = res_s2.status;
	assign dec.frame_done = res_s2.frame_done;

	`B64D_ASSERT(a_empty_beat_is_frame_end, clk, arst_n,
		(dec.valid && !dec.byte_valid) |-> dec.frame_done,
		"result beat carries neither byte nor frame end")
	`B64D_ASSERT(a_status_only_at_end, clk, arst_n,
		(dec.valid && !dec.frame_done) |-> (dec.status == b64d_pkg::ST_OK),
		"status set on a beat that is not the frame end")
	`B64D_ASSERT(a_no_byte_zero, clk, arst_n,
		(dec.valid && !dec.byte_valid) |-> (dec.out_byte == 8'd0),
		"byte field not cleared without byte_valid")
	`B64D_NEVER(a_s1_lost, clk, arst_n,
		valid_s1 && !adv && enc.ready,
		"input stage overwritten while stalled")

endmodule

/* sim/tb_base64_stream_decoder.sv */
// Self-checking testbench for the URL-safe base64 stream decoder.
`timescale 1ns / 1ps
module tb_base64_stream_decoder;

	localparam int STALL_LIMIT    = 3000;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PHASE_ITEMS    = 610;

	typedef struct packed {
		logic              byte_valid;
		logic [7:0]        data;
		b64d_pkg::status_t status;
		logic              done;
	} decoded_beat_t;

	// Tracks decoder state per payload and holds the beats still owed by the block.
	class decode_scoreboard;
		logic [11:0]   window;
		logic [2:0]    bits_left;
		bit            pad_seen;
		bit            bad_seen;
		bit            any_char;
		bit            any_byte;
		decoded_beat_t owed_q[$];
		int            mismatches;
		int            bytes_checked;
		int            frames_done;
		int            status_count[4];

		function new();
			clear_payload();
			mismatches    = 0;
			bytes_checked = 0;
			frames_done   = 0;
			for (int i = 0; i < 4; i++) status_count[i] = 0;
		endfunction

		function void clear_payload();
			window    = '0;
			bits_left = '0;
			pad_seen  = 0;
			bad_seen  = 0;
			any_char  = 0;
			any_byte  = 0;
		endfunction

		function int symbol_index(logic [7:0] c);
			if (c >= "A" && c <= "Z") return c - "A";
			if (c >= "a" && c <= "z") return c - "a" + 26;
			if (c >= "0" && c <= "9") return c - "0" + 52;
			if (c == "+" || c == "-") return 62;
			if (c == "/" || c == "_") return 63;
			return -1;
		endfunction

		function int outstanding();
			return owed_q.size();
		endfunction

		function void note_char(logic [7:0] c, logic last);
			decoded_beat_t beat;
			logic [11:0]   shifted;
			int            v;
			beat.byte_valid = 1'b0;
			beat.data       = 8'h00;
			beat.status     = b64d_pkg::ST_OK;
			beat.done       = 1'b0;
			if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))) begin
				any_char = 1;
				if (!pad_seen && !bad_seen) begin
					if (c == b64d_pkg::CHAR_PAD) begin
						pad_seen = 1;
					end else begin
						v = symbol_index(c);
						if (v < 0) begin
							bad_seen = 1;
						end else begin
							window = {window[5:0], v[5:0]};
							if (bits_left >= 3'd2) begin
								shifted         = window >> (bits_left - 3'd2);
								beat.byte_valid = 1'b1;
								beat.data       = shifted[7:0];
								any_byte        = 1;
								bits_left       = bits_left - 3'd2;
							end else begin
								bits_left = bits_left + 3'd6;
							end
						end
					end
				end
			end
			if (!beat.byte_valid && !last) return;
			if (last) begin
				if (!any_char) beat.status = b64d_pkg::ST_EMPTY;
				else if (bad_seen) beat.status = b64d_pkg::ST_INVALID;
				else if (!any_byte) beat.status = b64d_pkg::ST_NO_DATA;
				else beat.status = b64d_pkg::ST_OK;
				beat.done = 1'b1;
				status_count[beat.status]++;
				frames_done++;
				clear_payload();
			end
			owed_q = {owed_q, beat};
		endfunction

		function void check_beat(logic bv, logic [7:0] ob, logic [1:0] st, logic fd);
			decoded_beat_t beat;
			if (owed_q.size() == 0) begin
				$error("unexpected beat: byte_valid=%0d out_byte=%h status=%0d frame_done=%0d",
					bv, ob, st, fd);
				mismatches++;
				return;
			end
			beat = owed_q.pop_front();
			if (beat.byte_valid) bytes_checked++;
			if (bv !== beat.byte_valid) begin
				$error("byte_valid: expected %0d, actual %0d", beat.byte_valid, bv);
				mismatches++;
			end
			if (ob !== beat.data) begin
				$error("out_byte: expected %h, actual %h", beat.data, ob);
				mismatches++;
			end
			if (st !== beat.status) begin
				$error("status: expected %0d, actual %0d", beat.status, st);
				mismatches++;
			end
			if (fd !== beat.done) begin
				$error("frame_done: expected %0d, actual %0d", beat.done, fd);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	b64d_in_if  enc_ch();
	b64d_out_if dec_ch();

	base64_stream_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.enc    (enc_ch),
		.dec    (dec_ch)
	);

	decode_scoreboard sb;
	logic [7:0] frame_chars[$];
	int src_idle_pct;
	int sink_idle_pct;
	int chars_sent;
	int hold_req;
	int hold_ack;
	int hold_left;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random back-pressure, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  = hold_req;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			dec_ch.ready <= 1'b0;
		end else begin
			dec_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (enc_ch.valid && enc_ch.ready)
				sb.note_char(enc_ch.input_char, enc_ch.end_of_payload);
			if (dec_ch.valid && dec_ch.ready)
				sb.check_beat(dec_ch.byte_valid, dec_ch.out_byte, dec_ch.status,
					dec_ch.frame_done);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (enc_ch.valid && enc_ch.ready) || (dec_ch.valid && dec_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Call at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_char(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			enc_ch.valid <= 1'b0;
			@(negedge clk);
		end
		enc_ch.valid          <= 1'b1;
		enc_ch.input_char     <= c;
		enc_ch.end_of_payload <= last;
		@(posedge clk);
		while (!enc_ch.ready) @(posedge clk);
		@(negedge clk);
		chars_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_chars.size(); i++)
			send_char(frame_chars[i], i == frame_chars.size() - 1);
	endtask

	function automatic logic [7:0] b64_char(input logic [5:0] v, input bit url);
		if (v < 26) return 8'h41 + v;
		if (v < 52) return 8'(8'h61 + (v - 26));
		if (v < 62) return 8'(8'h30 + (v - 52));
		if (v == 62) return url ? "-" : "+";
		return url ? "_" : "/";
	endfunction

	function automatic logic [7:0] blank_char();
		int k;
		k = $urandom_range(5);
		return (k == 5) ? 8'h20 : 8'(8'h09 + k);
	endfunction

	// Encode random bytes into frame_chars, with optional padding and blanks.
	task automatic encode_random(input int nbytes, input bit pad, input int blank_pct);
		logic [23:0] word;
		int          left;
		int          nsym;
		frame_chars.delete();
		left = nbytes;
		while (left > 0) begin
			word = 24'($urandom);
			nsym = (left >= 3) ? 4 : left + 1;
			for (int s = 0; s < nsym; s++) begin
				if ($urandom_range(99) < blank_pct) frame_chars = {frame_chars, blank_char()};
				frame_chars = {frame_chars,
					b64_char(word[23 - 6 * s -: 6], $urandom_range(1))};
			end
			if (pad)
				for (int s = nsym; s < 4; s++)
					frame_chars = {frame_chars, b64d_pkg::CHAR_PAD};
			left = left - 3;
		end
	endtask

	task automatic send_random_payload();
		int kind;
		int nbytes;
		int n;
		kind   = $urandom_range(99);
		nbytes = ($urandom_range(19) == 0) ? $urandom_range(45) : $urandom_range(9);
		encode_random(nbytes, $urandom_range(1), ($urandom_range(3) == 0) ? 20 : 0);
		if (kind < 70) begin
			// well-formed as built
		end else if (kind < 78) begin
			if (frame_chars.size() > 0)
				frame_chars[$urandom_range(frame_chars.size() - 1)] = 8'($urandom_range(255));
			else
				frame_chars = {frame_chars, 8'($urandom_range(255))};
		end else if (kind < 84) begin
			// junk after padding must be ignored but still counts as characters
			frame_chars = {frame_chars, b64d_pkg::CHAR_PAD};
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++) frame_chars = {frame_chars, 8'($urandom_range(255))};
		end else if (kind < 90) begin
			n = $urandom_range(1, 3);
			for (int i = 0; i < n && frame_chars.size() > 0; i++) void'(frame_chars.pop_back());
		end else if (kind < 95) begin
			frame_chars.delete();
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++) frame_chars = {frame_chars, 8'($urandom_range(255))};
		end else begin
			frame_chars.delete();
			n = $urandom_range(3);
			for (int i = 0; i < n; i++) frame_chars = {frame_chars, blank_char()};
		end
		if ($urandom_range(99) < 15) frame_chars = {frame_chars, blank_char()};
		if (frame_chars.size() == 0) frame_chars = {frame_chars, blank_char()};
		send_frame();
	endtask

	task automatic run_phase(input int src_pct, input int sink_pct, input bit long_hold);
		int stop_at;
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		if (long_hold) hold_req++;
		stop_at = chars_sent + PHASE_ITEMS;
		while (chars_sent < stop_at) send_random_payload();
	endtask

	initial begin
		sb                    = new();
		arst_n                = 1'b0;
		enc_ch.valid          = 1'b0;
		enc_ch.input_char     = 8'h00;
		enc_ch.end_of_payload = 1'b0;
		dec_ch.ready          = 1'b0;
		src_idle_pct          = 25;
		sink_idle_pct         = 88;
		chars_sent            = 0;
		hold_req              = 0;
		hold_ack              = 0;
		hold_left             = 0;
		idle_cycles           = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// blanks only, ending on a blank: empty payload
		send_char(8'h20, 1'b0);
		send_char(8'h0D, 1'b1);
		// URL-safe and standard symbols decode alike
		send_char("-", 1'b0);
		send_char("_", 1'b0);
		send_char("+", 1'b0);
		send_char("/", 1'b1);
		// padding, then an invalid char that must be ignored, then a blank as the last beat
		send_char("Q", 1'b0);
		send_char("Q", 1'b0);
		send_char("=", 1'b0);
		send_char("=", 1'b0);
		send_char("%", 1'b0);
		send_char(8'h0A, 1'b1);
		// zero byte is invalid; nothing after it decodes
		send_char("Z", 1'b0);
		send_char("g", 1'b0);
		send_char(8'h00, 1'b0);
		send_char("Z", 1'b0);
		send_char("g", 1'b1);
		// non-ASCII byte alone
		send_char(8'hFF, 1'b1);
		// one symbol completes no byte
		send_char("z", 1'b0);
		send_char(8'h0B, 1'b0);
		send_char(8'h0C, 1'b0);
		send_char(8'h09, 1'b1);
		// padding alone
		send_char(b64d_pkg::CHAR_PAD, 1'b1);

		run_phase(25, 88, 1'b0);
		run_phase(88, 25, 1'b0);
		run_phase(0, 0, 1'b1);
		enc_ch.valid <= 1'b0;

		while (sb.outstanding() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters in %0d payloads; %0d decoded bytes checked.",
			chars_sent, sb.frames_done, sb.bytes_checked);
		$display("Payload endings: ok %0d, invalid %0d, empty %0d, nothing decoded %0d.",
			sb.status_count[b64d_pkg::ST_OK], sb.status_count[b64d_pkg::ST_INVALID],
			sb.status_count[b64d_pkg::ST_EMPTY], sb.status_count[b64d_pkg::ST_NO_DATA]);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
